// File: rtl/lru_prefer_clean_victim_select_assert.svh
// Assertion macros shared by the victim select RTL.
`ifndef LRU_PREFER_CLEAN_VICTIM_SELECT_ASSERT_SVH
`define LRU_PREFER_CLEAN_VICTIM_SELECT_ASSERT_SVH

`ifndef ASSERT_OFF

`define LPCV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define LPCV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define LPCV_ASSERT(lbl, prop, msg)

`define LPCV_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/lrupc_pkg.sv
// Shared constants and types for the LRU prefer-clean victim select block.
package lrupc_pkg;

    localparam int SETS       = 64;
    localparam int WAYS       = 8;
    localparam int STAMP_BITS = 32;

    localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_BITS = $clog2(WAYS + 1);
    localparam int LVL_BITS  = (WAY_BITS > 1) ? $clog2(WAY_BITS) : 1;
    localparam int KEY_W     = STAMP_BITS + 2;

    localparam int SET_IN_W = 6;
    localparam int MASK_W   = 8;
    localparam int VICT_W   = 3;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFER_CLEAN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE  = 1'd1;

    typedef logic [STAMP_BITS-1:0] t_stamp;
    typedef t_stamp [WAYS-1:0] t_row;

    typedef struct packed {
        logic                en;
        logic [SET_BITS-1:0] set;
        t_row                row;
    } t_row_wr;

endpackage

// File: rtl/lrupc_row_ram.sv
// Timestamp row memory, one row of stamps per set, unwritten rows read as zero.
module lrupc_row_ram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [lrupc_pkg::SET_BITS-1:0] i_rd_set,
    input  lrupc_pkg::t_row_wr            i_wr,
    output lrupc_pkg::t_row               o_rd_row
);
    import lrupc_pkg::*;

    t_row            r_mem [SETS];
    logic [SETS-1:0] r_valid;
    t_row            r_rd_data;
    logic            r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.set] <= i_wr.row;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.set] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_set];
            end
        end
    end

    assign o_rd_row = r_rd_ok ? r_rd_data : '0;

endmodule

// File: rtl/lru_prefer_clean_victim_select.sv
// Top level of the timestamp LRU victim select block with prefer-clean mode.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-----------------------------------------
//  in      | input     | i_valid / o_stall  | cmd, set_index, way_match_mask, dirty_mask
//  out     | output    | o_valid / i_stall  | victim_way
//  cfg     | input     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One word is in flight at a time; the input stalls until the state machine is idle again.
// An access is the row read, then the merged row write-back.
// A query is the row read, the key load, one comparator level per cycle,
// then the load of the output register.
// A result held by a stalled output blocks the next query in its last step;
// accesses still go on until then.
// Reset clears the per-set valid bits at once, so there is no clearing pass.
module lru_prefer_clean_victim_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_cmd,
    input  logic [lrupc_pkg::SET_IN_W-1:0]    i_set_index,
    input  logic [lrupc_pkg::MASK_W-1:0]      i_way_match_mask,
    input  logic [lrupc_pkg::MASK_W-1:0]      i_dirty_mask,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [lrupc_pkg::VICT_W-1:0]      o_victim_way,
    input  logic                              i_cfg_we,
    input  logic [lrupc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lrupc_pkg::CFG_W-1:0]       i_cfg_data
);
    import lrupc_pkg::*;

    `include "lru_prefer_clean_victim_select_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_REDUCE,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [LVL_BITS-1:0]    r_lvl;
    logic                   r_cmd;
    logic [SET_BITS-1:0]    r_set;
    logic [WAYS-1:0]        r_match;
    logic [WAYS-1:0]        r_dirty;
    t_stamp                 r_counter;
    logic                   r_prefer_clean;
    logic [WCNT_BITS-1:0]   r_ways_n;
    logic [KEY_W-1:0]       r_key [WAYS];
    logic [WAY_BITS-1:0]    r_idx [WAYS];
    logic                   r_out_valid;
    logic [VICT_W-1:0]      r_victim;

    logic [KEY_W-1:0]       n_key [WAYS];
    logic [WAY_BITS-1:0]    n_idx [WAYS];
    logic [KEY_W-1:0]       w_load_key [WAYS];
    logic [WAYS-1:0]        w_active;
    logic [WCNT_BITS-1:0]   w_cfg_ways;
    logic                   w_accept;
    logic                   w_out_free;
    t_row                   w_rd_row;
    t_row                   w_wr_row;
    t_row_wr                w_wr;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    lrupc_row_ram u_row_ram (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_accept),
        .i_rd_set (i_set_index[SET_BITS-1:0]),
        .i_wr     (w_wr),
        .o_rd_row (w_rd_row)
    );

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_ways = WCNT_BITS'(1);
        end else if (WCNT_BITS'(i_cfg_data) > WCNT_BITS'(WAYS)) begin
            w_cfg_ways = WCNT_BITS'(WAYS);
        end else begin
            w_cfg_ways = WCNT_BITS'(i_cfg_data);
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_active[w]   = WCNT_BITS'(w) < r_ways_n;
            w_load_key[w] = {!w_active[w], r_prefer_clean && r_dirty[w], w_rd_row[w]};
            if (w_active[w] && r_match[w]) begin
                w_wr_row[w] = r_counter;
            end else begin
                w_wr_row[w] = w_rd_row[w];
            end
        end
    end

    assign w_wr.en  = (r_state == S_READ) && (r_cmd == CMD_ACCESS);
    assign w_wr.set = r_set;
    assign w_wr.row = w_wr_row;

    // Each level keeps the smaller key of a pair, the lower way on a tie.
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            n_key[i] = r_key[i];
            n_idx[i] = r_idx[i];
        end
        for (int i = 0; i < WAYS / 2; i++) begin
            if (r_key[2 * i + 1] < r_key[2 * i]) begin
                n_key[i] = r_key[2 * i + 1];
                n_idx[i] = r_idx[2 * i + 1];
            end else begin
                n_key[i] = r_key[2 * i];
                n_idx[i] = r_idx[2 * i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_lvl          <= '0;
            r_counter      <= '0;
            r_prefer_clean <= 1'b1;
            r_ways_n       <= WCNT_BITS'(WAYS);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PREFER_CLEAN: r_prefer_clean <= i_cfg_data[0];
                    CFG_WAYS_IN_USE:  r_ways_n       <= w_cfg_ways;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_set   <= i_set_index[SET_BITS-1:0];
                        r_match <= i_way_match_mask[WAYS-1:0];
                        r_dirty <= i_dirty_mask[WAYS-1:0];
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_cmd == CMD_ACCESS) begin
                        if (r_counter != '1) begin
                            r_counter <= r_counter + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        for (int w = 0; w < WAYS; w++) begin
                            r_key[w] <= w_load_key[w];
                            r_idx[w] <= WAY_BITS'(w);
                        end
                        r_lvl   <= '0;
                        r_state <= (WAYS > 1) ? S_REDUCE : S_FINISH;
                    end
                end
                S_REDUCE: begin
                    for (int i = 0; i < WAYS; i++) begin
                        r_key[i] <= n_key[i];
                        r_idx[i] <= n_idx[i];
                    end
                    r_lvl <= r_lvl + 1'b1;
                    if (r_lvl == LVL_BITS'(WAY_BITS - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_victim    <= VICT_W'(r_idx[0]);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_victim_way = r_victim;

    `LPCV_ASSERT(a_out_from_finish, $rose(r_out_valid) |-> $past(r_state == S_FINISH),
                 "result word raised outside the final step")
    `LPCV_ASSERT(a_counter_monotonic, $past(i_rst_n) |-> r_counter >= $past(r_counter),
                 "access counter went backward")
    `LPCV_ASSERT(a_victim_in_use, r_out_valid |-> WCNT_BITS'(r_victim) < r_ways_n,
                 "victim way beyond the ways in use")

endmodule

// File: test/tb_lru_prefer_clean_victim_select.sv
// Testbench for the LRU prefer-clean victim select block, checked against its own predictor.
module tb_lru_prefer_clean_victim_select;
    timeunit 1ns;
    timeprecision 1ps;

    import lrupc_pkg::*;

    localparam int N_DIR         = 22;
    localparam int N_PHASES      = 10;
    localparam int PHASE_WORDS   = 165;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4 + WAY_BITS + 4;
    localparam int IDLE_LIMIT    = 20000;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic                cmd;
        logic [SET_IN_W-1:0] set;
        logic [MASK_W-1:0]   match;
        logic [MASK_W-1:0]   dirty;
    } t_lru_req;

    typedef struct packed {
        logic                cmd;
        logic [SET_IN_W-1:0] set;
        logic [MASK_W-1:0]   match;
        logic [MASK_W-1:0]   dirty;
        logic                has_way;
        logic [VICT_W-1:0]   way;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_cmd;
    logic [SET_IN_W-1:0]  i_set_index;
    logic [MASK_W-1:0]    i_way_match_mask;
    logic [MASK_W-1:0]    i_dirty_mask;
    logic                 o_valid;
    logic                 i_stall;
    logic [VICT_W-1:0]    o_victim_way;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    t_stamp            stamp_mem [SETS][WAYS];
    t_stamp            access_count;
    logic              prefer_clean_cfg;
    logic [CFG_W-1:0]  ways_cfg;
    logic [VICT_W-1:0] victim_q [$];

    t_dir_row         dir_rows [N_DIR];
    logic             phase_clean [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                                 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [CFG_W-1:0] phase_ways  [N_PHASES] = '{4'd8, 4'd8, 4'd1, 4'd0, 4'd15,
                                                 4'd4, 4'd9, 4'd3, 4'd2, 4'd7};

    int errors;
    int n_words;
    int n_checked;
    int cycles;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;

    lru_prefer_clean_victim_select uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_set_index      (i_set_index),
        .i_way_match_mask (i_way_match_mask),
        .i_dirty_mask     (i_dirty_mask),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_victim_way     (o_victim_way),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return $urandom_range(1, 3);
        if (r < 23) return $urandom_range(15, 50);
        return 0;
    endfunction

    function automatic int oldest_way(int s, int n, logic [MASK_W-1:0] allow);
        int best;
        best = -1;
        for (int w = 0; w < n; w++)
            if (allow[w] && (best < 0 || stamp_mem[s][w] < stamp_mem[s][best]))
                best = w;
        return best;
    endfunction

    // Updates the replacement state for one word and returns the victim for a query.
    function automatic bit lru_update_and_pick(t_lru_req r, output logic [VICT_W-1:0] victim);
        int n;
        int s;
        int best;
        logic [MASK_W-1:0] active;
        n = (ways_cfg == 0) ? 1 : ((ways_cfg > WAYS) ? WAYS : int'(ways_cfg));
        s = int'(r.set) % SETS;
        active = 8'hFF >> (8 - n);
        victim = '0;
        if (r.cmd == CMD_ACCESS) begin
            for (int w = 0; w < n; w++)
                if (r.match[w]) stamp_mem[s][w] = access_count;
            if (access_count != '1) access_count = access_count + 1'b1;
            return 1'b0;
        end
        best = -1;
        if (prefer_clean_cfg) best = oldest_way(s, n, active & ~r.dirty);
        if (best < 0) best = oldest_way(s, n, active);
        victim = VICT_W'(best);
        return 1'b1;
    endfunction

    function automatic t_lru_req rand_req();
        t_lru_req r;
        int k;
        r.cmd = ($urandom_range(0, 99) < 55) ? CMD_ACCESS : CMD_QUERY;
        k = $urandom_range(0, 9);
        r.set = (k < 7) ? SET_IN_W'($urandom_range(0, 3)) : SET_IN_W'($urandom);
        k = $urandom_range(0, 9);
        if (k == 0) r.match = '0;
        else if (k < 5) r.match = MASK_W'(1 << $urandom_range(0, 7));
        else r.match = MASK_W'($urandom);
        k = $urandom_range(0, 9);
        if (k == 0) r.dirty = '0;
        else if (k == 1) r.dirty = '1;
        else r.dirty = MASK_W'($urandom);
        return r;
    endfunction

    task automatic send_word(input t_lru_req r, input bit has_way, input logic [VICT_W-1:0] way);
        int gap;
        logic [VICT_W-1:0] victim;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_cmd            <= r.cmd;
        i_set_index      <= r.set;
        i_way_match_mask <= r.match;
        i_dirty_mask     <= r.dirty;
        do @(posedge i_clk); while (o_stall);
        if (lru_update_and_pick(r, victim)) victim_q.push_back(has_way ? way : victim);
        n_words++;
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (victim_q.size() != 0 && waited < IDLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic clean, input logic [CFG_W-1:0] ways);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PREFER_CLEAN;
        i_cfg_data  <= {(CFG_W - 1)'($urandom_range(0, 7)), clean};
        @(posedge i_clk);
        prefer_clean_cfg = clean;
        i_cfg_index <= CFG_WAYS_IN_USE;
        i_cfg_data  <= ways;
        @(posedge i_clk);
        ways_cfg = ways;
        i_cfg_we <= 1'b0;
    endtask

    // Receiving side: checks each accepted word and chooses its own stall pattern.
    initial begin
        logic [VICT_W-1:0] want;
        int stall_left;
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (victim_q.size() == 0) begin
                    $display("%0t: unexpected victim_way, expected none, actual %0d",
                             $time, o_victim_way);
                    errors++;
                end else begin
                    want = victim_q.pop_front();
                    n_checked++;
                    if (o_victim_way !== want) begin
                        $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                                 $time, want, o_victim_way);
                        errors++;
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && rx_idle_on) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_cmd            <= CMD_ACCESS;
        i_set_index      <= '0;
        i_way_match_mask <= '0;
        i_dirty_mask     <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_PREFER_CLEAN;
        i_cfg_data       <= '0;
        errors = 0;
        n_words = 0;
        n_checked = 0;
        hold_req = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++)
                stamp_mem[s][w] = '0;
        access_count = '0;
        prefer_clean_cfg = 1'b1;
        ways_cfg = CFG_W'(8);

        // The first rows read straight off a freshly reset row of all-zero stamps.
        dir_rows = '{
            '{CMD_QUERY,  6'd0,  8'h00, 8'h00, 1'b1, 3'd0},
            '{CMD_QUERY,  6'd63, 8'hFF, 8'h01, 1'b1, 3'd1},
            '{CMD_QUERY,  6'd0,  8'h00, 8'hFF, 1'b1, 3'd0},
            '{CMD_QUERY,  6'd5,  8'h00, 8'hFE, 1'b1, 3'd0},
            '{CMD_QUERY,  6'd5,  8'h00, 8'h7F, 1'b1, 3'd7},
            '{CMD_ACCESS, 6'd0,  8'hFF, 8'h00, 1'b0, 3'd0},
            '{CMD_ACCESS, 6'd0,  8'h01, 8'hFF, 1'b0, 3'd0},
            '{CMD_QUERY,  6'd0,  8'h00, 8'h00, 1'b0, 3'd0},
            '{CMD_ACCESS, 6'd0,  8'h00, 8'h00, 1'b0, 3'd0},
            '{CMD_ACCESS, 6'd0,  8'h02, 8'h00, 1'b0, 3'd0},
            '{CMD_QUERY,  6'd0,  8'h00, 8'h00, 1'b0, 3'd0},
            '{CMD_QUERY,  6'd0,  8'h00, 8'hFC, 1'b0, 3'd0},
            '{CMD_ACCESS, 6'd63, 8'h80, 8'h00, 1'b0, 3'd0},
            '{CMD_ACCESS, 6'd63, 8'h7F, 8'h00, 1'b0, 3'd0},
            '{CMD_QUERY,  6'd63, 8'h00, 8'h00, 1'b0, 3'd0},
            '{CMD_QUERY,  6'd63, 8'h00, 8'h7F, 1'b0, 3'd0},
            '{CMD_ACCESS, 6'd42, 8'hAA, 8'h55, 1'b0, 3'd0},
            '{CMD_QUERY,  6'd42, 8'h00, 8'h55, 1'b0, 3'd0},
            '{CMD_QUERY,  6'd42, 8'h00, 8'hAA, 1'b0, 3'd0},
            '{CMD_ACCESS, 6'd0,  8'hFF, 8'h00, 1'b0, 3'd0},
            '{CMD_QUERY,  6'd0,  8'h00, 8'h00, 1'b0, 3'd0},
            '{CMD_QUERY,  6'd0,  8'h00, 8'hFF, 1'b0, 3'd0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            send_word({dir_rows[i].cmd, dir_rows[i].set, dir_rows[i].match, dir_rows[i].dirty},
                      dir_rows[i].has_way, dir_rows[i].way);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            apply_setting(phase_clean[p], phase_ways[p]);
            tx_idle_on = !(p % 3 == 1 || p == 6);
            rx_idle_on = !(p % 3 == 2 || p == 6);
            // The output is held off long enough for the block to stall its input.
            if (p == 3) hold_req = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == 5 && k == PHASE_WORDS / 2) wait_idle();
                send_word(rand_req(), 1'b0, '0);
            end
            wait_idle();
        end

        if (victim_q.size() != 0) begin
            $display("%0t: %0d victim_way words never arrived", $time, victim_q.size());
            errors += victim_q.size();
        end
        $display("Sent %0d words and checked %0d victim choices over %0d register settings,",
                 n_words, n_checked, N_PHASES);
        $display("with ways in use from 0 to 15 and both plain and prefer-clean selection.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
